>>> src/cal_pkg.sv
// cal_pkg: shared types, constants and command codes for the card access lock controller
// no dependencies
`default_nettype none
package cal_pkg;
  localparam int TABLE_ENTRIES = 16;
  localparam int LOG_ENTRIES = 16;
  localparam int MAX_ID_BYTES = 10;
  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int LAW = $clog2(LOG_ENTRIES);
  localparam logic [13:0] PULSE_MIN = 14'd500;
  localparam logic [13:0] PULSE_MAX = 14'd15000;
  localparam logic [13:0] PULSE_RESET = 14'd3000;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_CARD = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_ADD = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;
  localparam logic [2:0] CMD_RD_ENTRY = 3'd6;
  localparam logic [2:0] CMD_RD_EVENT = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LEN = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_DUP = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  localparam logic [1:0] EV_GRANTED = 2'd0;
  localparam logic [1:0] EV_DENIED = 2'd1;
  localparam logic [1:0] EV_TOGGLE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_RDWAIT, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic scan_rd;   // read table at scan pointer
    logic scan_step; // advance scan pointer
    logic shift_wr;  // move entry down by one
    logic finish;    // commit command and form result
    logic item_rd;   // indexed read
  } cal_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;  // pointer reached fill
    logic hit;       // registered compare hit
    logic need_scan; // command needs table search
    logic is_read;
    logic shift_end;
    logic cmp_wait;  // a table read is still being compared
  } cal_stat_t;

  function automatic logic len_ok(input logic [3:0] n);
    return (n >= 4'd1) && (n <= 4'(MAX_ID_BYTES));
  endfunction
endpackage
`default_nettype wire

>>> src/card_access_lock_controller_unit.sv
// card_access_lock_controller_unit: top level of the card access lock controller
// depends on cal_pkg, cal_ctrl, cal_dp, cal_ram
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid / in_stall     | cmd uid_low uid_high uid_len index
//  out      | out_valid / out_stall   | ok status unlocked id_count ... time
//  config   | cfg_we                  | cfg_data (pulse_ticks, 500..15000)
//
// one beat at a time: a new beat is taken only once the last result has left;
// lookups and compaction walk the table read-then-compare on its one read port
// reset clears fill counts, log head, tick counter and the lock (locked)
// the result is held in output registers until out_stall drops
`default_nettype none
module card_access_lock_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] uid_low,
  input  wire logic [15:0] uid_high,
  input  wire logic [3:0]  uid_len,
  input  wire logic [3:0]  index,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        ok,
  output      logic [2:0]  status,
  output      logic        unlocked,
  output      logic [4:0]  id_count,
  output      logic [4:0]  log_count,
  output      logic [63:0] read_uid_low,
  output      logic [15:0] read_uid_high,
  output      logic [3:0]  read_uid_len,
  output      logic [1:0]  event_kind,
  output      logic [31:0] event_time
);
  cal_pkg::cal_cmd_t  ctl;
  cal_pkg::cal_stat_t st;

  // sequencer
  cal_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(ctl));

  // table, log, timer and result registers
  cal_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(ctl), .st(st), .cmd_in(cmd), .uid_low(uid_low), .uid_high(uid_high),
    .uid_len(uid_len), .index(index), .ok(ok), .status(status),
    .unlocked(unlocked), .id_count(id_count), .log_count(log_count),
    .read_uid_low(read_uid_low), .read_uid_high(read_uid_high),
    .read_uid_len(read_uid_len), .event_kind(event_kind), .event_time(event_time));

  // fill counts never pass their depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    id_count <= 5'(cal_pkg::TABLE_ENTRIES) && log_count <= 5'(cal_pkg::LOG_ENTRIES))
    else $error("fill count overflow");
  // no beat is taken while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");
  // log only grows by one per result
  a_log: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> (log_count == $past(log_count)) || (log_count == $past(log_count) + 5'd1))
    else $error("log count jump");
endmodule
`default_nettype wire

>>> src/cal_ram.sv
// cal_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module cal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/cal_ctrl.sv
// cal_ctrl: command sequencer for the card access lock controller
// depends on cal_pkg
`default_nettype none
module cal_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  output      logic                out_valid,
  input  wire logic                out_stall,
  input  wire cal_pkg::cal_stat_t  st,
  output      cal_pkg::cal_cmd_t   cmd
);
  cal_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= cal_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      cal_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = cal_pkg::S_SCAN;
        end
      end
      cal_pkg::S_SCAN: begin
        // search loop: read entry, compare next cycle
        if (st.is_read) begin
          cmd.item_rd = 1'b1;
          state_next = cal_pkg::S_RDWAIT;
        end else if (st.cmp_wait) begin
          state_next = cal_pkg::S_SCAN;
        end else if (!st.need_scan || st.hit || st.scan_end) begin
          if (st.hit && st.need_scan && !st.shift_end) state_next = cal_pkg::S_SHIFT;
          else begin
            cmd.finish = 1'b1;
            state_next = cal_pkg::S_DONE;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end
      cal_pkg::S_SHIFT: begin
        if (st.shift_end) begin
          cmd.finish = 1'b1;
          state_next = cal_pkg::S_DONE;
        end else cmd.shift_wr = 1'b1;
      end
      cal_pkg::S_RDWAIT: begin
        cmd.finish = 1'b1;
        state_next = cal_pkg::S_DONE;
      end
      cal_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = cal_pkg::S_IDLE;
      end
      default: state_next = cal_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> src/cal_dp.sv
// cal_dp: id table, event log, pulse timer and result registers
// depends on cal_pkg and cal_ram
`default_nettype none
module cal_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [13:0]       cfg_data,
  input  wire cal_pkg::cal_cmd_t cmd,
  output      cal_pkg::cal_stat_t st,
  input  wire logic [2:0]        cmd_in,
  input  wire logic [63:0]       uid_low,
  input  wire logic [15:0]       uid_high,
  input  wire logic [3:0]        uid_len,
  input  wire logic [3:0]        index,
  output      logic              ok,
  output      logic [2:0]        status,
  output      logic              unlocked,
  output      logic [4:0]        id_count,
  output      logic [4:0]        log_count,
  output      logic [63:0]       read_uid_low,
  output      logic [15:0]       read_uid_high,
  output      logic [3:0]        read_uid_len,
  output      logic [1:0]        event_kind,
  output      logic [31:0]       event_time
);
  localparam int TAW = cal_pkg::TAW;
  localparam int LAW = cal_pkg::LAW;
  localparam int TW = TAW + 1;
  localparam int LW = LAW + 1;

  logic [13:0] pulse_ticks;
  logic [2:0]  op;
  logic [63:0] key_main;
  logic [19:0] key_rest;
  logic [3:0]  idx;
  logic [TW-1:0] fill;
  logic [LW-1:0] lfill;
  logic [LAW-1:0] lhead;
  logic [31:0] tick_now, pulse_begin;
  logic        pulse_active;
  logic [TW-1:0] ptr;      // scan pointer, also shift position
  logic        cmp_pend;   // a table read is in flight
  logic        hit;
  logic        shifting;

  // normalized key from input beat
  logic [63:0] n_main;
  logic [15:0] n_hi;
  always_comb begin
    n_main = uid_low;
    if (uid_len == 4'd0) n_main = '0;
    else if (uid_len < 4'd8) n_main = uid_low & ~(64'hFFFF_FFFF_FFFF_FFFF >> (6'(uid_len) * 6'd8));
    n_hi = uid_high;
    if (uid_len <= 4'd8) n_hi = '0;
    else if (uid_len == 4'd9) n_hi = uid_high & 16'hFF00;
  end

  // table memories
  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [83:0]    t_wdata, t_rdata;
  cal_ram #(.WIDTH(84), .DEPTH(cal_pkg::TABLE_ENTRIES)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));

  logic           l_we;
  logic [LAW-1:0] l_raddr;
  logic [117:0]   l_wdata, l_rdata;
  cal_ram #(.WIDTH(118), .DEPTH(cal_pkg::LOG_ENTRIES)) u_log (
    .clk(clk), .we(l_we), .waddr(lhead), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  logic len_good, tbl_full, is_read;
  assign len_good = cal_pkg::len_ok(key_rest[19:16]);
  assign tbl_full = fill >= TW'(cal_pkg::TABLE_ENTRIES);
  assign is_read = (op == cal_pkg::CMD_RD_ENTRY) || (op == cal_pkg::CMD_RD_EVENT);

  always_comb begin
    st.need_scan = len_good && !cmp_pend && (
      (op == cal_pkg::CMD_CARD && !pulse_active) ||
      (op == cal_pkg::CMD_ADD && !tbl_full) ||
      (op == cal_pkg::CMD_REMOVE));
    // hold off finishing until the last compare lands
    if (cmp_pend) st.need_scan = 1'b1;
    st.scan_end = !cmp_pend && (ptr >= fill);
    st.hit = hit && !cmp_pend;
    st.is_read = is_read;
    st.shift_end = (op != cal_pkg::CMD_REMOVE) || (TW'(ptr) + TW'(1) >= fill);
    st.cmp_wait = cmp_pend;
  end

  // table port use: scan reads at ptr, shift reads one ahead of the entry it moves
  logic [TW-1:0] ptr_inc, ptr_inc2;
  assign ptr_inc = ptr + TW'(1);
  assign ptr_inc2 = ptr + TW'(2);
  always_comb begin
    t_raddr = ptr[TAW-1:0];
    if (cmd.item_rd) t_raddr = idx[TAW-1:0];
    else if (shifting) t_raddr = ptr_inc2[TAW-1:0];
    else if (hit && !cmd.scan_rd) t_raddr = ptr_inc[TAW-1:0];
    t_we = 1'b0;
    t_waddr = ptr[TAW-1:0];
    t_wdata = t_rdata;
    if (cmd.shift_wr && shifting) t_we = 1'b1;
    if (cmd.finish && op == cal_pkg::CMD_ADD && len_good && !tbl_full && !hit) begin
      t_we = 1'b1;
      t_waddr = fill[TAW-1:0];
      t_wdata = {key_main, key_rest};
    end
  end

  logic [LAW-1:0] ev_addr;
  assign ev_addr = (lfill < LW'(cal_pkg::LOG_ENTRIES)) ? idx[LAW-1:0] : lhead + idx[LAW-1:0];
  assign l_raddr = ev_addr;

  logic [1:0] ev_kind;
  logic       do_log;
  always_comb begin
    do_log = 1'b0;
    ev_kind = cal_pkg::EV_TOGGLE;
    l_wdata = {2'd0, tick_now, 84'd0};
    if (op == cal_pkg::CMD_TOGGLE) do_log = 1'b1;
    if (op == cal_pkg::CMD_CARD && !pulse_active && len_good) begin
      do_log = 1'b1;
      ev_kind = hit ? cal_pkg::EV_GRANTED : cal_pkg::EV_DENIED;
      l_wdata = {ev_kind, tick_now, key_main, key_rest};
    end
    l_wdata[117:116] = ev_kind;
    l_we = cmd.finish && do_log;
  end

  logic [31:0] tick_inc;
  assign tick_inc = tick_now + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= cal_pkg::PULSE_RESET;
      fill <= '0; lfill <= '0; lhead <= '0;
      tick_now <= '0; pulse_begin <= '0; pulse_active <= 1'b0;
      cmp_pend <= 1'b0; hit <= 1'b0; shifting <= 1'b0;
    end else begin
      if (cfg_we && cfg_data >= cal_pkg::PULSE_MIN && cfg_data <= cal_pkg::PULSE_MAX)
        pulse_ticks <= cfg_data;
      if (cmd.load) begin
        op <= cmd_in;
        key_main <= n_main;
        key_rest <= {uid_len, n_hi};
        idx <= index;
        ptr <= '0;
        hit <= 1'b0;
        cmp_pend <= 1'b0;
        shifting <= 1'b0;
      end
      if (cmd.scan_step) ptr <= ptr_inc;
      cmp_pend <= cmd.scan_rd;
      // pointer already stepped past the entry being compared
      if (cmp_pend && t_rdata == {key_main, key_rest}) begin
        hit <= 1'b1;
        ptr <= ptr - TW'(1);
      end
      // shift: first cycle primes read of ptr+1, then write and advance
      if (!cmd.scan_rd && hit && !cmp_pend && op == cal_pkg::CMD_REMOVE && !shifting
          && !cmd.finish)
        shifting <= 1'b1;
      if (cmd.shift_wr && shifting) ptr <= ptr_inc;
      if (cmd.finish) begin
        ok <= 1'b0; status <= cal_pkg::ST_OK;
        read_uid_low <= '0; read_uid_high <= '0; read_uid_len <= '0;
        event_kind <= '0; event_time <= '0;
        if (do_log) begin
          lhead <= lhead + LAW'(1);
          if (lfill < LW'(cal_pkg::LOG_ENTRIES)) lfill <= lfill + LW'(1);
        end
        case (op)
          cal_pkg::CMD_TICK: begin
            ok <= 1'b1;
            tick_now <= tick_inc;
            if (pulse_active && (tick_inc - pulse_begin) >= 32'(pulse_ticks))
              pulse_active <= 1'b0;
          end
          cal_pkg::CMD_CARD: begin
            if (pulse_active) status <= cal_pkg::ST_IGNORED;
            else if (!len_good) status <= cal_pkg::ST_BAD_LEN;
            else if (hit) begin
              pulse_active <= 1'b1; pulse_begin <= tick_now; ok <= 1'b1;
            end else status <= cal_pkg::ST_NOT_FOUND;
          end
          cal_pkg::CMD_TOGGLE: begin
            ok <= 1'b1;
            pulse_active <= !pulse_active;
            if (!pulse_active) pulse_begin <= tick_now;
          end
          cal_pkg::CMD_ADD: begin
            if (!len_good) status <= cal_pkg::ST_BAD_LEN;
            else if (tbl_full) status <= cal_pkg::ST_FULL;
            else if (hit) status <= cal_pkg::ST_DUP;
            else begin ok <= 1'b1; fill <= fill + TW'(1); end
          end
          cal_pkg::CMD_REMOVE: begin
            if (!len_good || !hit) status <= cal_pkg::ST_NOT_FOUND;
            else begin ok <= 1'b1; fill <= fill - TW'(1); end
          end
          cal_pkg::CMD_CLEAR: begin ok <= 1'b1; fill <= '0; end
          cal_pkg::CMD_RD_ENTRY: begin
            if (TW'(idx) >= fill) status <= cal_pkg::ST_BAD_INDEX;
            else begin
              ok <= 1'b1;
              read_uid_low <= t_rdata[83:20];
              read_uid_high <= t_rdata[15:0];
              read_uid_len <= t_rdata[19:16];
            end
          end
          default: begin
            if (LW'(idx) >= lfill) status <= cal_pkg::ST_BAD_INDEX;
            else begin
              ok <= 1'b1;
              read_uid_low <= l_rdata[83:20];
              read_uid_high <= l_rdata[15:0];
              read_uid_len <= l_rdata[19:16];
              event_kind <= l_rdata[117:116];
              event_time <= l_rdata[115:84];
            end
          end
        endcase
      end
    end
  end

  assign unlocked = pulse_active;
  assign id_count = 5'(fill);
  assign log_count = 5'(lfill);
endmodule
`default_nettype wire

>>> sim/card_access_lock_controller_unit_test.sv
// testbench for card_access_lock_controller_unit: directed and random command beats,
// a scoreboard that predicts every result beat, random gaps between input beats and random result stalls
// depends on cal_pkg and the rtl of the block
`timescale 1ns / 100ps
module card_access_lock_controller_unit_test;

  typedef struct {
    logic        ok;
    logic [2:0]  status;
    logic        unlocked;
    logic [4:0]  id_count;
    logic [4:0]  log_count;
    logic [63:0] rd_low;
    logic [15:0] rd_high;
    logic [3:0]  rd_len;
    logic [1:0]  kind;
    logic [31:0] stamp;
  } lock_result_t;

  // scoreboard: private copy of the controller state and a queue of predicted results
  class lock_scoreboard;
    logic [13:0] pulse_len;
    logic [63:0] tbl_main [cal_pkg::TABLE_ENTRIES];
    logic [19:0] tbl_rest [cal_pkg::TABLE_ENTRIES];
    int          tbl_fill;
    logic [63:0] ev_main [cal_pkg::LOG_ENTRIES];
    logic [19:0] ev_rest [cal_pkg::LOG_ENTRIES];
    logic [1:0]  ev_kind [cal_pkg::LOG_ENTRIES];
    logic [31:0] ev_stamp [cal_pkg::LOG_ENTRIES];
    int          ev_head, ev_fill;
    logic [31:0] now_tick, open_tick;
    logic        is_open;
    lock_result_t pending[$];
    int          errors, checked;

    function new();
      pulse_len = cal_pkg::PULSE_RESET;
      tbl_fill = 0; ev_head = 0; ev_fill = 0;
      now_tick = 0; open_tick = 0; is_open = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_pulse(logic [13:0] v);
      if (v >= cal_pkg::PULSE_MIN && v <= cal_pkg::PULSE_MAX) pulse_len = v;
    endfunction

    function int lookup(logic [63:0] m, logic [19:0] r);
      for (int i = 0; i < tbl_fill; i++)
        if (tbl_main[i] == m && tbl_rest[i] == r) return i;
      return -1;
    endfunction

    function void log_it(logic [1:0] k, logic [63:0] m, logic [19:0] r);
      ev_main[ev_head] = m; ev_rest[ev_head] = r;
      ev_kind[ev_head] = k; ev_stamp[ev_head] = now_tick;
      ev_head = (ev_head + 1) % cal_pkg::LOG_ENTRIES;
      if (ev_fill < cal_pkg::LOG_ENTRIES) ev_fill++;
    endfunction

    // notes an accepted input beat and predicts its result
    function void note_command(logic [2:0] c, logic [63:0] lo, logic [15:0] hi,
                               logic [3:0] n, logic [3:0] idx);
      lock_result_t e;
      logic [63:0] m;
      logic [15:0] mh;
      logic [19:0] r;
      logic good_len;
      int pos, slot;
      e = '{default: '0};
      good_len = (n >= 1 && n <= cal_pkg::MAX_ID_BYTES);
      m = lo;
      if (n == 0) m = '0;
      else if (n < 8) m = lo & ({64{1'b1}} << (64 - 8 * n));
      mh = (n <= 8) ? 16'h0 : (n == 9) ? (hi & 16'hFF00) : hi;
      r = {n, mh};
      case (c)
        cal_pkg::CMD_TICK: begin
          now_tick++;
          if (is_open && (now_tick - open_tick) >= {18'd0, pulse_len}) is_open = 0;
          e.ok = 1;
        end
        cal_pkg::CMD_CARD: begin
          if (is_open) e.status = cal_pkg::ST_IGNORED;
          else if (!good_len) e.status = cal_pkg::ST_BAD_LEN;
          else if (lookup(m, r) >= 0) begin
            is_open = 1; open_tick = now_tick;
            log_it(cal_pkg::EV_GRANTED, m, r);
            e.ok = 1;
          end else begin
            log_it(cal_pkg::EV_DENIED, m, r);
            e.status = cal_pkg::ST_NOT_FOUND;
          end
        end
        cal_pkg::CMD_TOGGLE: begin
          if (is_open) is_open = 0;
          else begin
            is_open = 1; open_tick = now_tick;
          end
          log_it(cal_pkg::EV_TOGGLE, '0, '0);
          e.ok = 1;
        end
        cal_pkg::CMD_ADD: begin
          if (!good_len) e.status = cal_pkg::ST_BAD_LEN;
          else if (tbl_fill >= cal_pkg::TABLE_ENTRIES) e.status = cal_pkg::ST_FULL;
          else if (lookup(m, r) >= 0) e.status = cal_pkg::ST_DUP;
          else begin
            tbl_main[tbl_fill] = m; tbl_rest[tbl_fill] = r;
            tbl_fill++;
            e.ok = 1;
          end
        end
        cal_pkg::CMD_REMOVE: begin
          pos = good_len ? lookup(m, r) : -1;
          if (pos < 0) e.status = cal_pkg::ST_NOT_FOUND;
          else begin
            for (int i = pos; i + 1 < tbl_fill; i++) begin
              tbl_main[i] = tbl_main[i + 1]; tbl_rest[i] = tbl_rest[i + 1];
            end
            tbl_fill--;
            e.ok = 1;
          end
        end
        cal_pkg::CMD_CLEAR: begin
          tbl_fill = 0;
          e.ok = 1;
        end
        cal_pkg::CMD_RD_ENTRY: begin
          if (idx >= tbl_fill) e.status = cal_pkg::ST_BAD_INDEX;
          else begin
            e.rd_low = tbl_main[idx]; e.rd_high = tbl_rest[idx][15:0];
            e.rd_len = tbl_rest[idx][19:16];
            e.ok = 1;
          end
        end
        default: begin
          if (idx >= ev_fill) e.status = cal_pkg::ST_BAD_INDEX;
          else begin
            slot = (ev_fill < cal_pkg::LOG_ENTRIES) ? idx
                                                    : (ev_head + idx) % cal_pkg::LOG_ENTRIES;
            e.rd_low = ev_main[slot]; e.rd_high = ev_rest[slot][15:0];
            e.rd_len = ev_rest[slot][19:16];
            e.kind = ev_kind[slot]; e.stamp = ev_stamp[slot];
            e.ok = 1;
          end
        end
      endcase
      e.unlocked = is_open;
      e.id_count = 5'(tbl_fill);
      e.log_count = 5'(ev_fill);
      pending.push_back(e);
    endfunction

    // compares one result beat with the oldest prediction
    function void check_result(lock_result_t got);
      lock_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.ok !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, got.ok); errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.unlocked !== e.unlocked) begin
        $error("unlocked: expected %0d, got %0d", e.unlocked, got.unlocked); errors++;
      end
      if (got.id_count !== e.id_count) begin
        $error("id_count: expected %0d, got %0d", e.id_count, got.id_count); errors++;
      end
      if (got.log_count !== e.log_count) begin
        $error("log_count: expected %0d, got %0d", e.log_count, got.log_count); errors++;
      end
      if (got.rd_low !== e.rd_low) begin
        $error("read_uid_low: expected %h, got %h", e.rd_low, got.rd_low); errors++;
      end
      if (got.rd_high !== e.rd_high) begin
        $error("read_uid_high: expected %h, got %h", e.rd_high, got.rd_high); errors++;
      end
      if (got.rd_len !== e.rd_len) begin
        $error("read_uid_len: expected %0d, got %0d", e.rd_len, got.rd_len); errors++;
      end
      if (got.kind !== e.kind) begin
        $error("event_kind: expected %0d, got %0d", e.kind, got.kind); errors++;
      end
      if (got.stamp !== e.stamp) begin
        $error("event_time: expected %0d, got %0d", e.stamp, got.stamp); errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        cfg_we = 0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 0, in_stall;
  logic [2:0]  cmd = cal_pkg::CMD_TICK;
  logic [63:0] uid_low = '0;
  logic [15:0] uid_high = '0;
  logic [3:0]  uid_len = '0, index = '0;
  logic        out_valid, out_stall = 0;
  logic        ok, unlocked;
  logic [2:0]  status;
  logic [4:0]  id_count, log_count;
  logic [63:0] read_uid_low;
  logic [15:0] read_uid_high;
  logic [3:0]  read_uid_len;
  logic [1:0]  event_kind;
  logic [31:0] event_time;

  card_access_lock_controller_unit uut (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_stall, .cmd, .uid_low, .uid_high, .uid_len, .index,
    .out_valid, .out_stall, .ok, .status, .unlocked, .id_count, .log_count,
    .read_uid_low, .read_uid_high, .read_uid_len, .event_kind, .event_time
  );

  lock_scoreboard board = new();

  // a small pool of card ids so that adds, duplicates, grants and removes happen often
  logic [63:0] pool_low [12];
  logic [15:0] pool_high [12];
  logic [3:0]  pool_len [12];
  int          idle_cycles = 0;
  int          beats_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sends one command beat; inputs change on the falling edge only
  task automatic send_beat(logic [2:0] c, logic [63:0] lo, logic [15:0] hi,
                           logic [3:0] n, logic [3:0] idx);
    int g;
    g = gap_length();
    repeat (g + 1) @(negedge clk);
    in_valid <= 1;
    cmd <= c; uid_low <= lo; uid_high <= hi; uid_len <= n; index <= idx;
    // accept edge: valid high and stall low at the rising edge
    do @(posedge clk); while (in_stall);
    board.note_command(c, lo, hi, n, idx);
    beats_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  // pick a pool id, possibly with garbage in the bytes past its length
  task automatic send_pool(logic [2:0] c);
    int k;
    logic [63:0] junk;
    k = $urandom_range(0, 11);
    junk = {$urandom, $urandom};
    if (pool_len[k] < 8 && $urandom_range(0, 1))
      send_beat(c, pool_low[k] | (junk >> (8 * pool_len[k])), pool_high[k] | 16'($urandom),
                pool_len[k], 4'($urandom));
    else
      send_beat(c, pool_low[k], pool_high[k], pool_len[k], 4'($urandom));
  endtask

  // waits until every predicted result is in, plus the block's own tail
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_pulse(logic [13:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.write_pulse(v);
  endtask

  // result side: random stall, sample on the rising edge
  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 3) begin
        out_stall <= 1;
        repeat ($urandom_range(10, 50)) @(negedge clk);
        out_stall <= 0;
      end else
        out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  always @(posedge clk) begin
    lock_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.ok = ok; got.status = status; got.unlocked = unlocked;
      got.id_count = id_count; got.log_count = log_count;
      got.rd_low = read_uid_low; got.rd_high = read_uid_high; got.rd_len = read_uid_len;
      got.kind = event_kind; got.stamp = event_time;
      board.check_result(got);
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int p;
    for (int k = 0; k < 12; k++) begin
      pool_len[k] = (k < 10) ? 4'(k + 1) : 4'($urandom_range(1, 10));
      pool_low[k] = {$urandom, $urandom};
      pool_high[k] = 16'($urandom);
      if (pool_len[k] < 8) pool_low[k] &= {64{1'b1}} << (64 - 8 * pool_len[k]);
      if (pool_len[k] <= 8) pool_high[k] = 0;
      else if (pool_len[k] == 9) pool_high[k] &= 16'hFF00;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: smallest pulse first so ticks can relock quickly
    write_pulse(cal_pkg::PULSE_MIN);
    send_beat(cal_pkg::CMD_CARD, '1, '1, 4'd0, 4'd0);          // zero length card
    send_beat(cal_pkg::CMD_ADD, '1, '1, 4'd15, 4'd0);          // length past the limit
    send_beat(cal_pkg::CMD_ADD, '1, '1, 4'd10, 4'd0);          // all-ones, full length
    send_beat(cal_pkg::CMD_ADD, '1, '1, 4'd10, 4'd0);          // duplicate
    send_beat(cal_pkg::CMD_ADD, 64'h0, 16'h0, 4'd1, 4'd0);     // all-zero single byte
    send_beat(cal_pkg::CMD_RD_ENTRY, '0, '0, 4'd0, 4'd0);
    send_beat(cal_pkg::CMD_RD_ENTRY, '0, '0, 4'd0, 4'd15);     // index past fill
    send_beat(cal_pkg::CMD_CARD, 64'h5555_5555_5555_5555, 16'hAAAA, 4'd9, 4'd0); // denied
    send_beat(cal_pkg::CMD_CARD, '1, '1, 4'd10, 4'd0);         // granted
    send_beat(cal_pkg::CMD_CARD, '1, '1, 4'd10, 4'd0);         // ignored while open
    send_beat(cal_pkg::CMD_TOGGLE, '0, '0, 4'd0, 4'd0);        // cancels the pulse
    send_beat(cal_pkg::CMD_TOGGLE, '0, '0, 4'd0, 4'd0);        // starts a pulse
    send_beat(cal_pkg::CMD_RD_EVENT, '0, '0, 4'd0, 4'd0);
    send_beat(cal_pkg::CMD_RD_EVENT, '0, '0, 4'd0, 4'd15);
    send_beat(cal_pkg::CMD_REMOVE, '1, '1, 4'd10, 4'd0);
    send_beat(cal_pkg::CMD_REMOVE, '1, '1, 4'd10, 4'd0);       // now not found
    send_beat(cal_pkg::CMD_REMOVE, '0, '0, 4'd0, 4'd0);        // bad length remove
    send_beat(cal_pkg::CMD_CLEAR, '0, '0, 4'd0, 4'd0);
    write_pulse(cal_pkg::PULSE_MAX);
    write_pulse(14'd16383);                                    // out of range, ignored
    write_pulse(14'd499);                                      // out of range, ignored

    // random part in phases with different pulse lengths
    for (int ph = 0; ph < 6; ph++) begin
      write_pulse(ph == 5 ? cal_pkg::PULSE_MIN : 14'($urandom_range(cal_pkg::PULSE_MIN, 600)));
      for (int i = 0; i < 40; i++) begin
        p = $urandom_range(0, 99);
        if (p < 30) begin
          // short tick bursts let the pulse run out
          repeat ($urandom_range(1, 4))
            send_beat(cal_pkg::CMD_TICK, '0, '0, 4'($urandom), '0);
        end else if (p < 48) send_pool(cal_pkg::CMD_CARD);
        else if (p < 62) send_pool(cal_pkg::CMD_ADD);
        else if (p < 70) send_pool(cal_pkg::CMD_REMOVE);
        else if (p < 74) send_beat(cal_pkg::CMD_TOGGLE, {$urandom, $urandom}, 16'($urandom),
                                   4'($urandom), 4'($urandom));
        else if (p < 76) send_beat(cal_pkg::CMD_CLEAR, '0, '0, '0, '0);
        else if (p < 84) send_beat(cal_pkg::CMD_RD_ENTRY, '0, '0, '0, 4'($urandom));
        else if (p < 92) send_beat(cal_pkg::CMD_RD_EVENT, '0, '0, '0, 4'($urandom));
        else send_beat(3'($urandom), {$urandom, $urandom}, 16'($urandom),
                       4'($urandom), 4'($urandom));
        if (i == 20) drain();                         // sender holds off until all is back
      end
      // a run of ticks that crosses the pulse length at least once
      if (ph == 5) repeat (520) send_beat(cal_pkg::CMD_TICK, '0, '0, '0, '0);
    end
    // fill the table to force a full result
    for (int k = 0; k < 17; k++)
      send_beat(cal_pkg::CMD_ADD, {$urandom, $urandom}, 16'($urandom), 4'd10, '0);

    drain();
    $display("covered %0d command beats, %0d results checked", beats_sent, board.checked);
    $display("commands: tick card toggle add remove clear and both reads, pulse 500..15000");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
